[design/dfd_pkg.sv]
// ----------------------------------------------------------------------------
// dfd_pkg
// Shared types, constants and helpers for the disparity-to-depth colormap.
// ----------------------------------------------------------------------------
package dfd_pkg;

    // color table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    // divider: 32-bit quotient, split over DIV_STAGES register stages
    localparam int DIV_BITS   = 32;
    localparam int DIV_STAGES = 8;
    localparam int DIV_STEPS  = DIV_BITS / DIV_STAGES;

    localparam logic [7:0] CH_FULL = 8'd255;

    typedef enum logic {
        OP_PIXEL     = 1'b0,
        OP_TBL_WRITE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        CFG_DEPTH_SCALE   = 3'd0,
        CFG_NEAR_LIMIT    = 3'd1,
        CFG_FAR_LIMIT     = 3'd2,
        CFG_SKIP_COLUMNS  = 3'd3,
        CFG_PSEUDO_ENABLE = 3'd4
    } cfg_idx_t;

    // config values seen by the color stages
    typedef struct packed {
        logic [15:0] near_limit;
        logic [15:0] far_limit;
        logic        pseudo_enable;
    } dfd_cfg_t;

    // item sideband carried alongside the divider
    typedef struct packed {
        op_t         op;
        logic        skipped;
        logic        positive;
        logic [11:0] tidx;
        logic [23:0] tcolor;   // ch0 in [7:0], ch1 in [15:8], ch2 in [23:16]
    } dfd_side_t;

    // one divider stage word
    typedef struct packed {
        logic [DIV_BITS-1:0] num;   // dividend bits not yet consumed, MSB first
        logic [14:0]         rem;
        logic [14:0]         dvs;
        logic [DIV_BITS-1:0] quo;
        dfd_side_t           side;
    } dfd_dstage_t;

    // DIV_STEPS restoring-division steps
    function automatic dfd_dstage_t div_chunk(input dfd_dstage_t s);
        dfd_dstage_t r;
        logic [15:0] t;
        logic        qb;
        r = s;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            t  = {r.rem, r.num[DIV_BITS-1]};
            qb = (t >= {1'b0, r.dvs});
            if (qb)
            begin
                t = t - {1'b0, r.dvs};
            end
            r.rem = t[14:0];
            r.num = {r.num[DIV_BITS-2:0], 1'b0};
            r.quo = {r.quo[DIV_BITS-2:0], qb};
        end
        return r;
    endfunction

endpackage

[design/dfd_div_pipe.sv]
// ----------------------------------------------------------------------------
// dfd_div_pipe
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module dfd_div_pipe
    import dfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dfd_dstage_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output dfd_dstage_t out_data
);

    dfd_dstage_t             st_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0]   v_reg;
    logic [DIV_STAGES:0]     adv;
    dfd_dstage_t             st_in  [DIV_STAGES];
    logic [DIV_STAGES-1:0]   v_in;

    assign adv[DIV_STAGES] = out_ready;
    assign in_ready        = adv[0];
    assign out_valid       = v_reg[DIV_STAGES-1];
    assign out_data        = st_reg[DIV_STAGES-1];

    genvar i;
    generate
        for (i = 0; i < DIV_STAGES; i++)
        begin : g_stage
            if (i == 0)
            begin : g_first
                assign st_in[i] = in_data;
                assign v_in[i]  = in_valid;
            end
            else
            begin : g_next
                assign st_in[i] = st_reg[i-1];
                assign v_in[i]  = v_reg[i-1];
            end

            assign adv[i] = !v_reg[i] || adv[i+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (adv[i])
                begin
                    v_reg[i] <= v_in[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[i] && v_in[i])
                begin
                    st_reg[i] <= div_chunk(st_in[i]);
                end
            end
        end
    endgenerate

    // partial remainder stays below the divisor whenever the divisor is nonzero
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.dvs != 15'd0) |-> out_data.rem < out_data.dvs)
        else $error("divider remainder not below divisor");

endmodule

[design/dfd_color.sv]
// ----------------------------------------------------------------------------
// dfd_color
// Range check, color table access and output word assembly.
// ----------------------------------------------------------------------------
module dfd_color
    import dfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dfd_cfg_t    cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  dfd_dstage_t in_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // depth[32:0], ch0, ch1, ch2, color_written, zero pad
    output logic        m_tuser    // skipped
);

    localparam logic [31:0] LAST_IDX = 32'(TABLE_DEPTH - 1);

    typedef struct packed {
        op_t               op;
        logic              skipped;
        logic              positive;
        logic [31:0]       quo;
        logic              in_range;
        logic              above;
        logic              wen;
        logic [TBL_AW-1:0] addr;
        logic [23:0]       tcolor;
    } c1_t;

    typedef struct packed {
        logic        skipped;
        logic        positive;
        logic [31:0] quo;
        logic        in_range;
        logic        above;
    } c2_t;

    c1_t         c1_next, c1_reg;
    c2_t         c2_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        adv1, adv2, adv3;
    logic [23:0] rdata_reg;
    logic [23:0] mem [TABLE_DEPTH];
    logic [31:0] diff;

    logic        skipped_reg, written_reg;
    logic [32:0] depth_reg;
    logic [7:0]  ch0_reg, ch1_reg, ch2_reg;

    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // stage 1: compare against limits, form table address
    always_comb
    begin
        diff              = in_data.quo - {16'd0, cfg.near_limit};
        c1_next.op        = in_data.side.op;
        c1_next.skipped   = in_data.side.skipped;
        c1_next.positive  = in_data.side.positive;
        c1_next.quo       = in_data.quo;
        c1_next.in_range  = (in_data.quo >= {16'd0, cfg.near_limit})
                            && (in_data.quo <= {16'd0, cfg.far_limit});
        c1_next.above     = in_data.quo > {16'd0, cfg.far_limit};
        c1_next.wen       = {20'd0, in_data.side.tidx} < 32'(TABLE_DEPTH);
        c1_next.tcolor    = in_data.side.tcolor;
        if (in_data.side.op == OP_TBL_WRITE)
        begin
            c1_next.addr = TBL_AW'(in_data.side.tidx);
        end
        else if (diff > LAST_IDX)
        begin
            c1_next.addr = LAST_IDX[TBL_AW-1:0];
        end
        else
        begin
            c1_next.addr = diff[TBL_AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                // table writes end here, only pixels go on
                v2_reg <= v1_reg && (c1_reg.op == OP_PIXEL);
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            c1_reg <= c1_next;
        end
    end

    // stage 2: table write or read, in stream order
    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            if (c1_reg.op == OP_TBL_WRITE)
            begin
                if (c1_reg.wen)
                begin
                    mem[c1_reg.addr] <= c1_reg.tcolor;
                end
            end
            else
            begin
                rdata_reg <= mem[c1_reg.addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg && (c1_reg.op == OP_PIXEL))
        begin
            c2_reg.skipped  <= c1_reg.skipped;
            c2_reg.positive <= c1_reg.positive;
            c2_reg.quo      <= c1_reg.quo;
            c2_reg.in_range <= c1_reg.in_range;
            c2_reg.above    <= c1_reg.above;
        end
    end

    // stage 3: output word
    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            skipped_reg <= c2_reg.skipped;
            depth_reg   <= 33'd0;
            ch0_reg     <= 8'd0;
            ch1_reg     <= 8'd0;
            ch2_reg     <= 8'd0;
            written_reg <= 1'b0;
            if (!c2_reg.skipped)
            begin
                if (!c2_reg.positive)
                begin
                    depth_reg <= '1;
                end
                else
                begin
                    depth_reg <= {1'b0, c2_reg.quo};
                    if (cfg.pseudo_enable)
                    begin
                        written_reg <= 1'b1;
                        if (c2_reg.in_range)
                        begin
                            ch0_reg <= rdata_reg[7:0];
                            ch1_reg <= rdata_reg[15:8];
                            ch2_reg <= rdata_reg[23:16];
                        end
                        else if (c2_reg.above)
                        begin
                            ch2_reg <= CH_FULL;
                        end
                    end
                end
            end
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tuser  = skipped_reg;
    assign m_tdata  = {6'd0, written_reg, ch2_reg, ch1_reg, ch0_reg, depth_reg};

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && skipped_reg |-> (depth_reg == 33'd0) && !written_reg
            && (ch0_reg == 8'd0) && (ch1_reg == 8'd0) && (ch2_reg == 8'd0))
        else $error("skipped pixel carries nonzero fields");

    a_invalid_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && depth_reg[32] |-> !written_reg
            && (ch0_reg == 8'd0) && (ch1_reg == 8'd0) && (ch2_reg == 8'd0))
        else $error("invalid depth got a color");

    a_unwritten_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !written_reg |-> (ch0_reg == 8'd0) && (ch1_reg == 8'd0)
            && (ch2_reg == 8'd0))
        else $error("color present without color_written");

endmodule

[design/depth_from_disparity_colormap.sv]
// ----------------------------------------------------------------------------
// depth_from_disparity_colormap
// Disparity to depth conversion with pseudo color table lookup.
// ----------------------------------------------------------------------------
// Pipeline: 12 register stages, the input stage loading on the accept edge
//   itself (input stage, 8 divider stages of 4 quotient bits each, range
//   stage, table stage, output). Table writes give no result.
// Throughput: one word per cycle unless the result stream stalls; the pipelined
//   divider and single-port color table each take one item per cycle.
// Reset: config returns to defaults, all stage valids clear; the color table
//   is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
module depth_from_disparity_colormap
    import dfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // column[11:0], disparity[15:0], table_index[11:0],
                                   // table_ch0, table_ch1, table_ch2
    input  logic        s_tuser,   // opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // depth[32:0], color_ch0, color_ch1, color_ch2,
                                   // color_written, zero pad
    output logic        m_tuser,   // skipped
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // config registers
    logic [31:0] depth_scale_reg;
    logic [15:0] near_limit_reg;
    logic [15:0] far_limit_reg;
    logic [11:0] skip_columns_reg;
    logic        pseudo_enable_reg;
    dfd_cfg_t    cfg;

    // input stage
    dfd_dstage_t s0_next, s0_reg;
    logic        s0_v_reg;
    logic        s0_adv;

    // divider to color stages
    logic        div_in_ready;
    logic        div_out_valid;
    logic        col_in_ready;
    dfd_dstage_t div_out;

    logic [11:0] in_column;
    logic [15:0] in_disp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_scale_reg   <= 32'd0;
            near_limit_reg    <= 16'd0;
            far_limit_reg     <= 16'd4095;
            skip_columns_reg  <= 12'd64;
            pseudo_enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEPTH_SCALE:   depth_scale_reg   <= cfg_data;
                CFG_NEAR_LIMIT:    near_limit_reg    <= cfg_data[15:0];
                CFG_FAR_LIMIT:     far_limit_reg     <= cfg_data[15:0];
                CFG_SKIP_COLUMNS:  skip_columns_reg  <= cfg_data[11:0];
                CFG_PSEUDO_ENABLE: pseudo_enable_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg.near_limit    = near_limit_reg;
    assign cfg.far_limit     = far_limit_reg;
    assign cfg.pseudo_enable = pseudo_enable_reg;

    // decode: skip test and disparity sign check, seed the divider
    assign in_column = s_tdata[11:0];
    assign in_disp   = s_tdata[27:12];

    always_comb
    begin
        s0_next.num           = depth_scale_reg;
        s0_next.rem           = 15'd0;
        s0_next.dvs           = in_disp[14:0];
        s0_next.quo           = '0;
        s0_next.side.op       = op_t'(s_tuser);
        s0_next.side.skipped  = in_column < skip_columns_reg;
        s0_next.side.positive = !in_disp[15] && (in_disp != 16'd0);
        s0_next.side.tidx     = s_tdata[39:28];
        s0_next.side.tcolor   = s_tdata[63:40];
    end

    assign s0_adv   = !s0_v_reg || div_in_ready;
    assign s_tready = s0_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (s0_adv)
        begin
            s0_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv && s_tvalid)
        begin
            s0_reg <= s0_next;
        end
    end

    dfd_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_v_reg),
        .in_ready  (div_in_ready),
        .in_data   (s0_reg),
        .out_valid (div_out_valid),
        .out_ready (col_in_ready),
        .out_data  (div_out)
    );

    dfd_color u_color (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (div_out_valid),
        .in_ready (col_in_ready),
        .in_data  (div_out),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[dv/depth_color_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_color_checker
// Watches the pixel, result and config channels of the depth colormap block,
// predicts each pixel result from its own copy of the config and color table,
// and compares every result word field by field in arrival order.
// ----------------------------------------------------------------------------
module depth_color_checker
    import dfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          outstanding,
    output int          mismatches
);

    typedef struct packed {
        logic        skipped;
        logic [32:0] depth;
        logic [7:0]  ch0;
        logic [7:0]  ch1;
        logic [7:0]  ch2;
        logic        written;
    } pix_result_t;

    // shadow state
    logic [23:0] lut [TABLE_DEPTH];
    logic [31:0] scale;
    logic [15:0] near_lim;
    logic [15:0] far_lim;
    logic [11:0] skip_cols;
    logic        pseudo_on;

    pix_result_t expected_pixels [$];
    pix_result_t got;
    pix_result_t want;
    pix_result_t pred;
    logic [11:0] wr_idx;

    function automatic pix_result_t predict_depth_color(input logic [11:0] col,
                                                        input logic [15:0] disp);
        pix_result_t r;
        logic [31:0] q;
        logic [31:0] idx;
        logic [23:0] entry;
        r = '0;
        if (col < skip_cols)
        begin
            r.skipped = 1'b1;
            return r;
        end
        if (!disp[15] && disp != 16'd0)
        begin
            q       = scale / {16'd0, disp};
            r.depth = {1'b0, q};
            if (pseudo_on)
            begin
                r.written = 1'b1;
                if (q >= {16'd0, near_lim} && q <= {16'd0, far_lim})
                begin
                    idx = q - {16'd0, near_lim};
                    // past the end of the table: last entry
                    if (idx >= 32'(TABLE_DEPTH))
                    begin
                        idx = 32'(TABLE_DEPTH - 1);
                    end
                    entry = lut[idx[TBL_AW-1:0]];
                    r.ch0 = entry[7:0];
                    r.ch1 = entry[15:8];
                    r.ch2 = entry[23:16];
                end
                else if (q > {16'd0, far_lim})
                begin
                    r.ch2 = CH_FULL;
                end
            end
        end
        else
        begin
            r.depth = '1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale       = 32'd0;
            near_lim    = 16'd0;
            far_lim     = 16'd4095;
            skip_cols   = 12'd64;
            pseudo_on   = 1'b0;
            expected_pixels.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            // results first: a result never belongs to a word taken in the same cycle
            if (m_tvalid && m_tready)
            begin
                got.skipped = m_tuser;
                got.depth   = m_tdata[32:0];
                got.ch0     = m_tdata[40:33];
                got.ch1     = m_tdata[48:41];
                got.ch2     = m_tdata[56:49];
                got.written = m_tdata[57];
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: unexpected result skip=%0d depth=%h c=%h/%h/%h w=%0d",
                                 $realtime, got.skipped, got.depth, got.ch0, got.ch1,
                                 got.ch2, got.written);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: mismatch exp skip=%0d depth=%h c=%h/%h/%h w=%0d",
                                     $realtime, want.skipped, want.depth, want.ch0,
                                     want.ch1, want.ch2, want.written);
                            $display("%0t:          got skip=%0d depth=%h c=%h/%h/%h w=%0d",
                                     $realtime, got.skipped, got.depth, got.ch0,
                                     got.ch1, got.ch2, got.written);
                        end
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (op_t'(s_tuser) == OP_TBL_WRITE)
                begin
                    wr_idx = s_tdata[39:28];
                    if (32'(wr_idx) < 32'(TABLE_DEPTH))
                    begin
                        lut[wr_idx] = s_tdata[63:40];
                    end
                end
                else
                begin
                    pred            = predict_depth_color(s_tdata[11:0], s_tdata[27:12]);
                    expected_pixels = {expected_pixels, pred};
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_DEPTH_SCALE:   scale     = cfg_data;
                    CFG_NEAR_LIMIT:    near_lim  = cfg_data[15:0];
                    CFG_FAR_LIMIT:     far_lim   = cfg_data[15:0];
                    CFG_SKIP_COLUMNS:  skip_cols = cfg_data[11:0];
                    CFG_PSEUDO_ENABLE: pseudo_on = cfg_data[0];
                    default: ;
                endcase
            end

            outstanding = expected_pixels.size();
        end
    end

endmodule

[dv/depth_from_disparity_colormap_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_from_disparity_colormap_tb
// Drives disparity pixels and color table writes into the depth colormap
// block under bursty input and a stalling output, steps the config through
// several settings, and lets the checker judge every result word.
// ----------------------------------------------------------------------------
module depth_from_disparity_colormap_tb;

    import dfd_pkg::*;

    // pipeline is 12 deep; table writes leave nothing to wait on, so pad it
    localparam int DRAIN_CYCLES   = 24;
    // longest quiet stretch in a good run: a receiver stall, a sender gap or
    // the drain pad -- this is many times any of them
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 150;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    int outstanding;
    int mismatches;

    // sender burst bookkeeping
    int burst_left = 0;

    // current config, used only to aim the stimulus
    logic [31:0] cur_scale;
    logic [15:0] cur_near;
    logic [15:0] cur_far;
    logic [11:0] cur_skip;
    logic        cur_pe;

    // table entries already written; a lookup never hits one that is not
    logic        tbl_seen [TABLE_DEPTH];

    depth_from_disparity_colormap uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    depth_color_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Result side: modes that last a while -- always ready, coin flip, or
    // mostly ready with occasional long stalls.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int mode_left;
        int rx_mode;
        stall_left = 0;
        mode_left  = 0;
        rx_mode    = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default:
                    begin
                        if ($urandom_range(0, 15) == 0)
                        begin
                            stall_left = $urandom_range(5, 30);
                            m_tready  <= 1'b0;
                        end
                        else
                        begin
                            m_tready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no channel has moved a word for too long.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input word: called at a falling edge, returns at a falling edge after
    // the word is taken. Starts a new burst, usually with a gap before it,
    // when the current one runs out.
    // ------------------------------------------------------------------------
    task automatic push_word(input op_t op, input logic [11:0] col, input logic [15:0] disp,
                             input logic [11:0] tidx, input logic [7:0] c0,
                             input logic [7:0] c1, input logic [7:0] c2);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        // tdata: column, disparity, table_index, ch0, ch1, ch2 from bit 0 up
        s_tdata  <= {c2, c1, c0, tidx, disp, col};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    // table write; pixel fields are don't-care and get noise
    task automatic tbl_write(input logic [11:0] idx, input logic [7:0] c0,
                             input logic [7:0] c1, input logic [7:0] c2);
        push_word(OP_TBL_WRITE, 12'($urandom), 16'($urandom), idx, c0, c1, c2);
        tbl_seen[idx] = 1'b1;
    endtask

    // pixel word; table fields are don't-care and get noise. An entry that
    // this pixel would look up gets a random color first if still unwritten.
    task automatic pixel(input logic [11:0] col, input logic [15:0] disp);
        logic [31:0] q;
        logic [31:0] idx;
        if (cur_pe && (col >= cur_skip) && !disp[15] && (disp != 16'd0))
        begin
            q = cur_scale / {16'd0, disp};
            if (q >= {16'd0, cur_near} && q <= {16'd0, cur_far})
            begin
                idx = q - {16'd0, cur_near};
                if (idx >= 32'(TABLE_DEPTH))
                begin
                    idx = 32'(TABLE_DEPTH - 1);
                end
                if (!tbl_seen[idx[TBL_AW-1:0]])
                begin
                    tbl_write(idx[TBL_AW-1:0], 8'($urandom), 8'($urandom), 8'($urandom));
                end
            end
        end
        push_word(OP_PIXEL, col, disp, 12'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    // hold the sender off until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    task automatic cfg_word(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // full register set, only once the pipe is empty
    task automatic set_config(input logic [31:0] scale, input logic [15:0] near_v,
                              input logic [15:0] far_v, input logic [11:0] skip,
                              input logic pe);
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_word(CFG_DEPTH_SCALE, scale);
        cfg_word(CFG_NEAR_LIMIT, {16'd0, near_v});
        cfg_word(CFG_FAR_LIMIT, {16'd0, far_v});
        cfg_word(CFG_SKIP_COLUMNS, {20'd0, skip});
        cfg_word(CFG_PSEUDO_ENABLE, {31'd0, pe});
        cfg_valid <= 1'b0;
        cur_scale = scale;
        cur_near  = near_v;
        cur_far   = far_v;
        cur_skip  = skip;
        cur_pe    = pe;
    endtask

    // ------------------------------------------------------------------------
    // Random phase. Half the pixels aim at a depth around the near/far window
    // so table lookups, the clamp and both out-of-range colors get exercised;
    // the rest is raw noise, non-positive and edge disparities. About one word
    // in ten is a table write. Midway the sender waits for the pipe to empty.
    // ------------------------------------------------------------------------
    task automatic run_random_phase(input int count);
        int          k;
        int          sel;
        longint      span;
        longint      lo;
        longint      hi;
        longint      t;
        longint      d;
        longint      c;
        logic [11:0] col;
        logic [15:0] disp;
        for (k = 0; k < count; k++)
        begin
            if (k == count / 2)
            begin
                drain_results();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                tbl_write(12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 50)
                begin
                    // aim at a target depth: disparity = scale / depth
                    span = (cur_far >= cur_near) ? longint'(cur_far - cur_near) : 256;
                    lo   = (longint'(cur_near) > span / 4) ? longint'(cur_near) - span / 4 : 0;
                    hi   = longint'(cur_far) + span / 4 + 1;
                    if (hi <= lo)
                    begin
                        hi = lo + 65536;
                    end
                    t = lo + longint'($urandom_range(0, 32'(hi - lo)));
                    d = longint'(cur_scale) / ((t == 0) ? 1 : t);
                    if (d < 1)
                    begin
                        d = 1;
                    end
                    if (d > 32767)
                    begin
                        d = 32767;
                    end
                    disp = 16'(d);
                end
                else if (sel < 65)
                begin
                    disp = 16'($urandom);
                end
                else if (sel < 75)
                begin
                    disp = ($urandom_range(0, 3) == 0) ? 16'd0 : {1'b1, 15'($urandom)};
                end
                else if (sel < 90)
                begin
                    disp = 16'($urandom_range(1, 16));
                end
                else
                begin
                    disp = 16'($urandom_range(16384, 32767));
                end

                sel = $urandom_range(0, 99);
                if (sel < 70)
                begin
                    col = 12'($urandom_range(cur_skip, 4095));
                end
                else if (sel < 85)
                begin
                    // around the skip boundary
                    c = longint'(cur_skip) + $urandom_range(0, 3) - 2;
                    if (c < 0)
                    begin
                        c = 0;
                    end
                    col = 12'(c);
                end
                else
                begin
                    col = 12'($urandom);
                end
                pixel(col, disp);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        int p;
        logic [15:0] nv;

        cur_scale = 32'd0;
        cur_near  = 16'd0;
        cur_far   = 16'd4095;
        cur_skip  = 12'd64;
        cur_pe    = 1'b0;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_seen[i] = 1'b0;
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: skip 64, scale 0, colors off
        pixel(12'd63, 16'd5);       // last skipped column
        pixel(12'd64, 16'd5);       // first live column, depth 0
        pixel(12'd64, 16'd0);       // zero disparity

        // directed: window 100..5000, scale 1e6
        set_config(32'd1000000, 16'd100, 16'd5000, 12'd64, 1'b1);
        pixel(12'd0, 16'd100);      // skipped
        pixel(12'd63, 16'd100);     // skipped
        pixel(12'd64, 16'd0);       // zero disparity
        pixel(12'd4095, 16'hFFFF);  // -1 disparity
        pixel(12'd100, 16'h8000);   // most negative disparity
        pixel(12'd100, 16'd32767);  // depth 30, below near: black
        pixel(12'd100, 16'd1);      // depth 1e6, beyond far: blue
        pixel(12'd100, 16'd200);    // depth 5000 = far, index clamps to last entry
        tbl_write(12'd0, 8'hFF, 8'h00, 8'hA5);
        pixel(12'd100, 16'd10000);  // depth 100 = near, reads fresh entry 0
        tbl_write(12'd4095, 8'h00, 8'hFF, 8'h5A);
        pixel(12'd100, 16'd200);    // clamp reads fresh last entry
        pixel(12'd100, 16'd1000);   // depth 1000, inside window
        pixel(12'd100, 16'd199);    // depth 5025, just past far

        // colors off
        set_config(32'd1000000, 16'd100, 16'd5000, 12'd2048, 1'b0);
        pixel(12'd2047, 16'd1000);  // skipped
        pixel(12'd2048, 16'd1000);  // depth only

        // near above far: nothing maps into the table
        set_config(32'd1000000, 16'd5000, 16'd100, 12'd0, 1'b1);
        pixel(12'd0, 16'd1000);     // between, but above far: blue
        pixel(12'd0, 16'd1);        // beyond far: blue
        pixel(12'd0, 16'd10000);    // depth equals far: black

        // random phases, extremes first
        set_config(32'hFFFF_FFFF, 16'd0, 16'hFFFF, 12'd0, 1'b1);
        run_random_phase(PHASE_WORDS);
        set_config(32'd0, 16'd0, 16'd0, 12'd2048, 1'b1);
        run_random_phase(PHASE_WORDS);
        set_config($urandom, 16'hFFFF, 16'd0, 12'($urandom_range(0, 2048)), 1'b1);
        run_random_phase(PHASE_WORDS);
        set_config($urandom, 16'hFFFF, 16'hFFFF, 12'($urandom_range(0, 2048)), 1'b1);
        run_random_phase(PHASE_WORDS);
        set_config($urandom, 16'($urandom), 16'($urandom), 12'($urandom_range(0, 2048)), 1'b0);
        run_random_phase(PHASE_WORDS);
        for (p = 0; p < 4; p++)
        begin
            nv = 16'($urandom_range(0, 3000));
            set_config(32'(nv + 1) * $urandom_range(1, 2000), nv,
                       nv + 16'($urandom_range(0, 6000)), 12'($urandom_range(0, 2048)), 1'b1);
            run_random_phase(PHASE_WORDS);
        end

        drain_results();
        repeat (DRAIN_CYCLES * 2) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
